// File: src/assert_macros.svh
// assertion macros shared by the checker files
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define PFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal holds its value in the cycle after a condition
`define PFBA_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// File: src/pfba_pkg.sv
// package of the page frame bitmap allocator: field widths, codes, reset values
// no dependencies
package pfba_pkg;

  localparam int unsigned MAX_PAGES_DEF = 4096;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;
  localparam int unsigned WRD_W  = CNT_W - BIT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;
  localparam logic [CNT_W-1:0] START_HINT_RST = 13'd9;
  localparam logic [CNT_W-1:0] USED_START_RST = 13'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_MARK    = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_ALREADY = 2'd2,
    STS_RANGE   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_COUNT = 2'd0,
    REG_START_HINT = 2'd1,
    REG_USED_START = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_t;

endpackage

// File: src/pfba_intf.sv
// channel interfaces of the allocator: request, response and register write
// depends on pfba_pkg
interface pfba_req_if;
  import pfba_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] page_index;
  modport source (output valid, action, page_index, input ready);
  modport sink   (input valid, action, page_index, output ready);
endinterface

interface pfba_rsp_if;
  import pfba_pkg::*;
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [IDX_W-1:0] granted_index;
  logic [CNT_W-1:0] free_pages;
  logic [CNT_W-1:0] used_pages;
  modport source (output valid, status, granted_index, free_pages, used_pages, input ready);
  modport sink   (input valid, status, granted_index, free_pages, used_pages, output ready);
endinterface

interface pfba_cfg_if;
  import pfba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/pfba_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pfba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pfba_find.sv
// first-free finder: lowest set bit of a candidate word
// depends on pfba_pkg
module pfba_find (
  input  logic [pfba_pkg::WORD_W-1:0] cand_i,
  output pfba_pkg::find_t             res_o
);
  import pfba_pkg::*;

  always_comb begin
    res_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand_i[i]) begin
        res_o.found   = 1'b1;
        res_o.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

// File: src/page_frame_bitmap_allocator.sv
// Page frame allocator with a one-bit-per-page used map and a next-fit hint.
// The map lives in a ram of 32-bit words read one word per cycle. After reset
// the ram is cleared one word a cycle, all MAX_PAGES (capped at 8191) over 32
// rounded up words (128 at the default, at most 256), before the first request
// is taken; register writes are taken at any time and belong between requests.
// A page request is accepted in idle, where the word of the hint is read, and
// then checks one 32-page word per cycle from the hint word upward until it
// finds a free page or reaches page_count (capped at MAX_PAGES and 8191).
// Free and mark read the word of the page on accept and update it in the next
// state. The response sits in an output register; a finished request holds in
// its last state while an earlier response is still not taken.
// depends on pfba_pkg, pfba_intf, pfba_ram, pfba_find
module page_frame_bitmap_allocator #(
  parameter int unsigned MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfba_req_if.sink   req_i,
  pfba_rsp_if.source rsp_o,
  pfba_cfg_if.sink   cfg_i
);
  import pfba_pkg::*;

  localparam int unsigned LIM_CAP = (MAX_PAGES < 8192) ? MAX_PAGES : 8191;
  localparam int unsigned DEPTH   = (LIM_CAP + WORD_W - 1) / WORD_W;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [WRD_W-1:0] word_q, word_d;
  logic             first_q, first_d;
  logic [CNT_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] pcount_q, pcount_d;
  logic             out_valid_q, out_valid_d;
  logic [STS_W-1:0] out_sts_q, out_sts_d;
  logic [IDX_W-1:0] out_grant_q, out_grant_d;
  logic [CNT_W-1:0] out_free_q, out_free_d;
  logic [CNT_W-1:0] out_used_q, out_used_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  limit;
  logic [WORD_W-1:0] lo_mask, hi_mask, cand;
  find_t             find;
  logic [WRD_W:0]    nxt_word;
  logic [CNT_W:0]    nxt_base;
  logic [CNT_W-1:0]  page;
  logic [WRD_W-1:0]  start_word;
  logic [BIT_W-1:0]  idx_bit;
  logic              out_room, finish, want, take, give;

  assign limit = (pcount_q < CNT_W'(LIM_CAP)) ? pcount_q : CNT_W'(LIM_CAP);

  always_comb begin
    lo_mask = first_q ? ({WORD_W{1'b1}} << hint_q[BIT_W-1:0]) : {WORD_W{1'b1}};
    if (word_q < limit[CNT_W-1:BIT_W]) begin
      hi_mask = {WORD_W{1'b1}};
    end else if (word_q == limit[CNT_W-1:BIT_W]) begin
      hi_mask = ~({WORD_W{1'b1}} << limit[BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
    cand = ~ram_rdata & lo_mask & hi_mask;
  end

  pfba_find u_find (
    .cand_i (cand),
    .res_o  (find)
  );

  pfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign nxt_word   = {1'b0, word_q} + {{WRD_W{1'b0}}, 1'b1};
  assign nxt_base   = {nxt_word, {BIT_W{1'b0}}};
  assign page       = {word_q, find.bit_idx};
  assign idx_bit    = idx_q[BIT_W-1:0];
  assign want       = (act_q == ACT_MARK);
  assign out_room   = !out_valid_q || rsp_o.ready;
  assign start_word = (req_i.action == ACT_REQUEST) ? hint_q[CNT_W-1:BIT_W]
                                                    : {1'b0, req_i.page_index[IDX_W-1:BIT_W]};

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    act_d       = act_q;
    idx_d       = idx_q;
    word_d      = word_q;
    first_d     = first_q;
    hint_d      = hint_q;
    free_d      = free_q;
    used_d      = used_q;
    pcount_d    = pcount_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_sts_d   = out_sts_q;
    out_grant_d = out_grant_q;
    out_free_d  = out_free_q;
    out_used_d  = out_used_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = word_q[AW-1:0];
    finish      = 1'b0;
    take        = 1'b0;
    give        = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          act_d     = req_i.action;
          idx_d     = req_i.page_index;
          first_d   = 1'b1;
          word_d    = start_word;
          ram_re    = 1'b1;
          ram_raddr = start_word[AW-1:0];
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (act_q == ACT_REQUEST) begin
          if (find.found) begin
            if (out_room) begin
              ram_we      = 1'b1;
              ram_wdata   = ram_rdata | (WORD_W'(1) << find.bit_idx);
              take        = 1'b1;
              hint_d      = page + CNT_W'(1);
              out_sts_d   = STS_OK;
              out_grant_d = page[IDX_W-1:0];
              finish      = 1'b1;
            end
          end else if (nxt_base < {1'b0, limit}) begin
            ram_re    = 1'b1;
            ram_raddr = nxt_word[AW-1:0];
            word_d    = nxt_word[WRD_W-1:0];
            first_d   = 1'b0;
          end else if (out_room) begin
            if (hint_q < limit) begin
              hint_d = limit;
            end
            out_sts_d   = STS_NO_FREE;
            out_grant_d = '0;
            finish      = 1'b1;
          end
        end else if (out_room) begin
          finish      = 1'b1;
          out_grant_d = '0;
          if (!(act_q inside {ACT_FREE, ACT_MARK}) || ({1'b0, idx_q} >= limit)) begin
            out_sts_d = STS_RANGE;
          end else if (ram_rdata[idx_bit] == want) begin
            out_sts_d = STS_ALREADY;
          end else begin
            out_sts_d = STS_OK;
            ram_we    = 1'b1;
            if (want) begin
              ram_wdata = ram_rdata | (WORD_W'(1) << idx_bit);
              take      = 1'b1;
            end else begin
              ram_wdata = ram_rdata & ~(WORD_W'(1) << idx_bit);
              give      = 1'b1;
              if (hint_q > {1'b0, idx_q}) begin
                hint_d = {1'b0, idx_q};
              end
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (take) begin
      if (free_q != '0) begin
        free_d = free_q - CNT_W'(1);
      end
      if (used_q != CNT_MAX) begin
        used_d = used_q + CNT_W'(1);
      end
    end
    if (give) begin
      if (free_q != CNT_MAX) begin
        free_d = free_q + CNT_W'(1);
      end
      if (used_q != '0) begin
        used_d = used_q - CNT_W'(1);
      end
    end
    if (finish) begin
      out_valid_d = 1'b1;
      out_free_d  = free_d;
      out_used_d  = used_d;
      state_d     = S_IDLE;
    end

    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PAGE_COUNT: begin
          pcount_d = cfg_i.data;
          free_d   = cfg_i.data;
        end
        REG_START_HINT: hint_d = cfg_i.data;
        REG_USED_START: used_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      first_q     <= 1'b0;
      hint_q      <= START_HINT_RST;
      free_q      <= PAGE_COUNT_RST;
      used_q      <= USED_START_RST;
      pcount_q    <= PAGE_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      first_q     <= first_d;
      hint_q      <= hint_d;
      free_q      <= free_d;
      used_q      <= used_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    out_sts_q   <= out_sts_d;
    out_grant_q <= out_grant_d;
    out_free_q  <= out_free_d;
    out_used_q  <= out_used_d;
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_sts_q;
  assign rsp_o.granted_index = out_grant_q;
  assign rsp_o.free_pages    = out_free_q;
  assign rsp_o.used_pages    = out_used_q;

endmodule

// File: src/pfba_checker.sv
// port-level checker for the allocator, attached by the bind at the end
// depends on pfba_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [pfba_pkg::STS_W-1:0] rsp_status_i,
  input logic [pfba_pkg::IDX_W-1:0] rsp_grant_i,
  input logic [pfba_pkg::CNT_W-1:0] rsp_free_i,
  input logic [pfba_pkg::CNT_W-1:0] rsp_used_i
);
  import pfba_pkg::*;

  logic rsp_stall;
  logic [STS_W+IDX_W+2*CNT_W-1:0] rsp_payload;

  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_payload = {rsp_status_i, rsp_grant_i, rsp_free_i, rsp_used_i};

  `PFBA_ASSERT(a_rsp_valid_holds, rsp_stall |=> rsp_valid_i, "response dropped while stalled")
  `PFBA_ASSERT_HOLD(a_rsp_payload_holds, rsp_stall, rsp_payload, "stalled response changed")
  `PFBA_ASSERT(a_one_in_flight, (req_valid_i && req_ready_i) |=> !req_ready_i, "second request taken while busy")
  `PFBA_ASSERT(a_grant_only_ok, (rsp_valid_i && rsp_status_i != STS_OK) |-> (rsp_grant_i == '0), "granted index on a failed request")

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_grant_i  (rsp_o.granted_index),
  .rsp_free_i   (rsp_o.free_pages),
  .rsp_used_i   (rsp_o.used_pages)
);
